FILE: src/z80il_pkg.sv
// ----------------------------------------------------------------------------
// z80il_pkg
// Shared types and opcode constants for the Z80 instruction length and
// control-flow decoder.
// ----------------------------------------------------------------------------
package z80il_pkg;

  // Control-flow class of one decoded instruction.
  typedef enum logic [2:0] {
    FL_FALL   = 3'd0,
    FL_COND   = 3'd1,
    FL_UNCOND = 3'd2,
    FL_CALL   = 3'd3,
    FL_STOP   = 3'd4
  } flow_t;

  // One instruction position: its address and the next four code bytes.
  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
  } req_t;

  // Decode result for one instruction position.
  typedef struct packed {
    logic [2:0]  length;
    flow_t       flow;
    logic        target_valid;
    logic [15:0] target;
    logic        read_ref_valid;
    logic [15:0] read_ref;
    logic        write_ref_valid;
    logic [15:0] write_ref;
    logic        undecoded;
  } rsp_t;

  // Prefix bytes.
  localparam logic [7:0] OP_CB = 8'hCB;
  localparam logic [7:0] OP_ED = 8'hED;
  localparam logic [7:0] OP_DD = 8'hDD;
  localparam logic [7:0] OP_FD = 8'hFD;

  // Unprefixed and prefixed opcodes with special flow handling, and the base of the ED block group.
  localparam logic [7:0] OP_HALT  = 8'h76;
  localparam logic [7:0] ED_RETN  = 8'h45;
  localparam logic [7:0] ED_RETI  = 8'h4D;
  localparam logic [7:0] IX_JP_HL = 8'hE9;
  localparam logic [7:0] ED_BLOCK = 8'hA0;

  // Masks used to match opcode groups.
  localparam logic [7:0] MASK_XZ  = 8'hC7;
  localparam logic [7:0] MASK_XQZ = 8'hCF;

  // Instruction lengths.
  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

endpackage

FILE: src/z80il_if.sv
// ----------------------------------------------------------------------------
// z80il_req_if / z80il_rsp_if
// Valid/ready channels carrying decoder requests and decode results.
// ----------------------------------------------------------------------------
interface z80il_req_if;
  logic             valid;
  logic             ready;
  z80il_pkg::req_t  req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface z80il_rsp_if;
  logic             valid;
  logic             ready;
  z80il_pkg::rsp_t  rsp;

  modport source (output valid, output rsp, input ready);
  modport sink   (input valid, input rsp, output ready);
endinterface

FILE: src/z80_instruction_length_flow_decode.sv
// ----------------------------------------------------------------------------
// z80_instruction_length_flow_decode
// Z80 instruction length and control-flow decoder with an input register,
// a combinational decode and a result register.
// ----------------------------------------------------------------------------
// A request passes from the input register through the decode into the result register.
// Throughput: one request per cycle while the output is not stalled; the decode
// between the input and the result register is the only logic on the data path.
// A stalled result holds in the result register while the input register
// can still take one more request.
// Reset clears both valid flags; payload registers are not reset.
module z80_instruction_length_flow_decode (
  input  logic               clk,
  input  logic               rst_n,
  z80il_req_if.sink          in_chan,
  z80il_rsp_if.source        out_chan
);

  logic            s1_valid_r;
  logic            s1_valid_nxt;
  z80il_pkg::req_t s1_req_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  z80il_pkg::rsp_t out_r;
  z80il_pkg::rsp_t dec_rsp;
  logic            s1_ready;
  logic            s2_ready;

  z80il_decode u_decode (
    .req_i (s1_req_r),
    .rsp_o (dec_rsp)
  );

  assign s2_ready = !out_valid_r || out_chan.ready;
  assign s1_ready = !s1_valid_r || s2_ready;

  assign in_chan.ready  = s1_ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.rsp   = out_r;

  always_comb begin
    s1_valid_nxt  = s1_ready ? in_chan.valid : s1_valid_r;
    out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) begin
      s1_req_r <= in_chan.req;
    end
    if (s2_ready && s1_valid_r) begin
      out_r <= dec_rsp;
    end
  end

  // A request held in the input register is never dropped while the output stalls.
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(s1_req_r))
    else $error("input register lost a pending request");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.length >= z80il_pkg::LEN_1) &&
                    (out_r.length <= z80il_pkg::LEN_4))
    else $error("instruction length out of range");

  a_undecoded_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.undecoded |->
      (out_r.flow == z80il_pkg::FL_FALL) && !out_r.target_valid &&
      !out_r.read_ref_valid && !out_r.write_ref_valid)
    else $error("undecoded result carries flow or reference information");

  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.target_valid |-> (out_r.target == 16'h0000))
    else $error("target set without target_valid");

endmodule

FILE: src/z80il_decode.sv
// ----------------------------------------------------------------------------
// z80il_decode
// Combinational decode of one instruction window: length, flow class,
// target and direct memory references for the main, CB, ED and DD/FD pages.
// ----------------------------------------------------------------------------
module z80il_decode (
  input  z80il_pkg::req_t req_i,
  output z80il_pkg::rsp_t rsp_o
);

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [15:0] w12;
  logic [15:0] w23;
  logic [15:0] rel;
  logic [1:0]  x;
  logic [2:0]  y;
  logic [2:0]  z;
  logic [1:0]  p;
  logic        q;

  // ED page group matches.
  logic ed_stop;
  logic ed_plain;
  logic ed_st_word;
  logic ed_ld_word;
  logic ed_block;

  // DD/FD page group matches.
  logic ix_plain;
  logic ix_mem3;
  logic ix_len4;

  assign b0  = req_i.byte0;
  assign b1  = req_i.byte1;
  assign w12 = {req_i.byte2, req_i.byte1};
  assign w23 = {req_i.byte3, req_i.byte2};
  // Relative jumps are taken from the address after the two-byte instruction.
  assign rel = req_i.address + 16'd2 + {{8{b1[7]}}, b1};

  assign x = b0[7:6];
  assign y = b0[5:3];
  assign z = b0[2:0];
  assign p = y[2:1];
  assign q = y[0];

  always_comb begin
    ed_stop    = (b1 == z80il_pkg::ED_RETN) || (b1 == z80il_pkg::ED_RETI);
    ed_plain   = (b1 == 8'h44) || (b1 == 8'h46) || (b1 == 8'h56) || (b1 == 8'h5E) ||
                 (b1 == 8'h47) || (b1 == 8'h4F) || (b1 == 8'h57) || (b1 == 8'h5F) ||
                 (b1 == 8'h67) || (b1 == 8'h6F) ||
                 ((b1 & z80il_pkg::MASK_XZ) == 8'h40) ||
                 ((b1 & z80il_pkg::MASK_XZ) == 8'h41) ||
                 ((b1 & z80il_pkg::MASK_XQZ) == 8'h42) ||
                 ((b1 & z80il_pkg::MASK_XQZ) == 8'h4A);
    ed_st_word = (b1 & z80il_pkg::MASK_XQZ) == 8'h43;
    ed_ld_word = (b1 & z80il_pkg::MASK_XQZ) == 8'h4B;
    // Undefined codes in the upper range with bit 2 clear pass as block ops.
    ed_block   = (b1 >= z80il_pkg::ED_BLOCK) && !b1[2];

    ix_plain = (b1 == 8'h23) || (b1 == 8'h2B) || (b1 == 8'hE5) || (b1 == 8'hE1) ||
               (b1 == 8'hF9) || (b1 == 8'hE3);
    ix_mem3  = (((b1 & z80il_pkg::MASK_XZ) == 8'h46) && (b1 != z80il_pkg::OP_HALT)) ||
               ((b1 & 8'hF8) == 8'h70) || (b1 == 8'h34) || (b1 == 8'h35) ||
               ((b1[7:6] == 2'b10) && (b1[2:0] == 3'd6));
    ix_len4  = (b1 == 8'h36) || (b1 == z80il_pkg::OP_CB);
  end

  always_comb begin
    rsp_o = '{length: z80il_pkg::LEN_1, flow: z80il_pkg::FL_FALL,
              target_valid: 1'b0, target: 16'h0000,
              read_ref_valid: 1'b0, read_ref: 16'h0000,
              write_ref_valid: 1'b0, write_ref: 16'h0000,
              undecoded: 1'b0};

    priority if (b0 == z80il_pkg::OP_CB) begin
      rsp_o.length = z80il_pkg::LEN_2;
    end else if (b0 == z80il_pkg::OP_ED) begin
      rsp_o.length = z80il_pkg::LEN_2;
      priority if (ed_stop) begin
        rsp_o.flow = z80il_pkg::FL_STOP;
      end else if (ed_plain) begin
        rsp_o.length = z80il_pkg::LEN_2;
      end else if (ed_st_word) begin
        rsp_o.length          = z80il_pkg::LEN_4;
        rsp_o.write_ref_valid = 1'b1;
        rsp_o.write_ref       = w23;
      end else if (ed_ld_word) begin
        rsp_o.length         = z80il_pkg::LEN_4;
        rsp_o.read_ref_valid = 1'b1;
        rsp_o.read_ref       = w23;
      end else if (ed_block) begin
        rsp_o.length = z80il_pkg::LEN_2;
      end else begin
        rsp_o.undecoded = 1'b1;
      end
    end else if ((b0 == z80il_pkg::OP_DD) || (b0 == z80il_pkg::OP_FD)) begin
      rsp_o.length = z80il_pkg::LEN_2;
      priority if (b1 == 8'h21) begin
        rsp_o.length = z80il_pkg::LEN_4;
      end else if (b1 == 8'h22) begin
        rsp_o.length          = z80il_pkg::LEN_4;
        rsp_o.write_ref_valid = 1'b1;
        rsp_o.write_ref       = w23;
      end else if (b1 == 8'h2A) begin
        rsp_o.length         = z80il_pkg::LEN_4;
        rsp_o.read_ref_valid = 1'b1;
        rsp_o.read_ref       = w23;
      end else if (ix_plain) begin
        rsp_o.length = z80il_pkg::LEN_2;
      end else if (b1 == z80il_pkg::IX_JP_HL) begin
        rsp_o.flow = z80il_pkg::FL_STOP;
      end else if (ix_mem3) begin
        rsp_o.length = z80il_pkg::LEN_3;
      end else if (ix_len4) begin
        rsp_o.length = z80il_pkg::LEN_4;
      end else begin
        // Unknown index form: the prefix stands alone as a data byte.
        rsp_o.length    = z80il_pkg::LEN_1;
        rsp_o.undecoded = 1'b1;
      end
    end else begin
      unique case (x)
        2'd0: begin
          unique case (z)
            3'd0: begin
              if (y >= 3'd2) begin
                rsp_o.length       = z80il_pkg::LEN_2;
                rsp_o.target_valid = 1'b1;
                rsp_o.target       = rel;
                rsp_o.flow         = (y == 3'd3) ? z80il_pkg::FL_UNCOND
                                                 : z80il_pkg::FL_COND;
              end
            end
            3'd1: begin
              if (!q) begin
                rsp_o.length = z80il_pkg::LEN_3;
              end
            end
            3'd2: begin
              if (p >= 2'd2) begin
                rsp_o.length = z80il_pkg::LEN_3;
                if (!q) begin
                  rsp_o.write_ref_valid = 1'b1;
                  rsp_o.write_ref       = w12;
                end else begin
                  rsp_o.read_ref_valid = 1'b1;
                  rsp_o.read_ref       = w12;
                end
              end
            end
            3'd6: begin
              rsp_o.length = z80il_pkg::LEN_2;
            end
            default: begin
            end
          endcase
        end
        2'd1: begin
          if (b0 == z80il_pkg::OP_HALT) begin
            rsp_o.flow = z80il_pkg::FL_STOP;
          end
        end
        2'd2: begin
        end
        2'd3: begin
          unique case (z)
            3'd1: begin
              if (q && ((p == 2'd0) || (p == 2'd2))) begin
                rsp_o.flow = z80il_pkg::FL_STOP;
              end
            end
            3'd2: begin
              rsp_o.length       = z80il_pkg::LEN_3;
              rsp_o.target_valid = 1'b1;
              rsp_o.target       = w12;
              rsp_o.flow         = z80il_pkg::FL_COND;
            end
            3'd3: begin
              if (y == 3'd0) begin
                rsp_o.length       = z80il_pkg::LEN_3;
                rsp_o.target_valid = 1'b1;
                rsp_o.target       = w12;
                rsp_o.flow         = z80il_pkg::FL_UNCOND;
              end else if (y <= 3'd3) begin
                rsp_o.length = z80il_pkg::LEN_2;
              end
            end
            3'd4: begin
              rsp_o.length       = z80il_pkg::LEN_3;
              rsp_o.target_valid = 1'b1;
              rsp_o.target       = w12;
              rsp_o.flow         = z80il_pkg::FL_CALL;
            end
            3'd5: begin
              if (q && (p == 2'd0)) begin
                rsp_o.length       = z80il_pkg::LEN_3;
                rsp_o.target_valid = 1'b1;
                rsp_o.target       = w12;
                rsp_o.flow         = z80il_pkg::FL_CALL;
              end
            end
            3'd6: begin
              rsp_o.length = z80il_pkg::LEN_2;
            end
            3'd7: begin
              // Restart vector comes straight from the opcode's y field.
              rsp_o.target_valid = 1'b1;
              rsp_o.target       = {10'd0, y, 3'd0};
              rsp_o.flow         = z80il_pkg::FL_CALL;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule
